>>> rtl/core/mtp_pkg.sv
// shared types and constants of the minutiae template parser
// no dependencies
`default_nettype none

package mtp_pkg;

  localparam int unsigned HEADER_LAST_BYTE = 27;
  localparam int unsigned WIDTH_HI_BYTE    = 14;
  localparam int unsigned WIDTH_LO_BYTE    = 15;
  localparam int unsigned HEIGHT_HI_BYTE   = 16;
  localparam int unsigned HEIGHT_LO_BYTE   = 17;
  localparam int unsigned RECORD_LEN       = 6;
  localparam int unsigned RECORD_STORE     = RECORD_LEN - 1;
  localparam int unsigned COORD_BITS       = 14;
  localparam int unsigned TYPE_BITS        = 2;
  localparam int unsigned RESULT_DEPTH     = 2;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_MINUTIA = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [15:0]           image_width;
    logic [15:0]           image_height;
    logic [7:0]            minutia_count;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [7:0]            angle_code;
    logic [TYPE_BITS-1:0]  minutia_type;
    logic [7:0]            minutia_quality;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mtp_parse.sv
// header and record parsing state, forms one result word per emitting byte
// depends on mtp_pkg
`default_nettype none

module mtp_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first_byte,
  output logic                 res_valid,
  output mtp_pkg::result_t     res
);
  import mtp_pkg::*;

  localparam int unsigned RIDX_BITS = $clog2(RECORD_LEN);

  logic [4:0]           byte_position, byte_position_next;
  logic [RIDX_BITS-1:0] record_index, record_index_next;
  logic [15:0]          width_reg, width_reg_next;
  logic [15:0]          height_reg, height_reg_next;
  logic [7:0]           count_reg, count_reg_next;
  logic [7:0]           remaining, remaining_next;
  logic                 in_records, in_records_next;
  logic [7:0]           record_bytes [RECORD_STORE];
  logic                 rec_we;
  logic                 emit;

  always_comb begin
    // a start flag restarts the position before this byte is used
    byte_position_next = first_byte ? 5'd0 : byte_position;
    record_index_next  = first_byte ? '0 : record_index;
    remaining_next     = first_byte ? 8'd0 : remaining;
    in_records_next    = first_byte ? 1'b0 : in_records;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    count_reg_next     = count_reg;
    rec_we             = 1'b0;
    emit               = 1'b0;
    res                = '0;

    if (!in_records_next) begin
      case (byte_position_next)
        5'(WIDTH_HI_BYTE):    width_reg_next[15:8]  = data_byte;
        5'(WIDTH_LO_BYTE):    width_reg_next[7:0]   = data_byte;
        5'(HEIGHT_HI_BYTE):   height_reg_next[15:8] = data_byte;
        5'(HEIGHT_LO_BYTE):   height_reg_next[7:0]  = data_byte;
        5'(HEADER_LAST_BYTE): count_reg_next        = data_byte;
        default: ;
      endcase
      if (byte_position_next >= 5'(HEADER_LAST_BYTE)) begin
        in_records_next   = 1'b1;
        remaining_next    = count_reg_next;
        record_index_next = '0;
        emit              = 1'b1;
        res.kind          = KIND_HEADER;
        res.last          = (count_reg_next == 8'd0);
      end else begin
        byte_position_next = byte_position_next + 5'd1;
      end
    end else if (remaining_next != 8'd0) begin
      if (record_index_next < RIDX_BITS'(RECORD_STORE)) begin
        rec_we            = 1'b1;
        record_index_next = record_index_next + RIDX_BITS'(1);
      end else begin
        remaining_next      = remaining_next - 8'd1;
        record_index_next   = '0;
        emit                = 1'b1;
        res.kind            = KIND_MINUTIA;
        res.last            = (remaining_next == 8'd0);
        res.pos_x           = {record_bytes[0][COORD_BITS-9:0], record_bytes[1]};
        res.pos_y           = {record_bytes[2][COORD_BITS-9:0], record_bytes[3]};
        res.minutia_type    = record_bytes[0][7 -: TYPE_BITS];
        // negated angle wraps mod 256
        res.angle_code      = 8'd0 - record_bytes[4];
        res.minutia_quality = data_byte;
      end
    end

    res.image_width   = width_reg_next;
    res.image_height  = height_reg_next;
    res.minutia_count = count_reg_next;
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 5'd0;
      record_index  <= '0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      count_reg     <= 8'd0;
      remaining     <= 8'd0;
      in_records    <= 1'b0;
    end else if (step) begin
      byte_position <= byte_position_next;
      record_index  <= record_index_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      count_reg     <= count_reg_next;
      remaining     <= remaining_next;
      in_records    <= in_records_next;
    end
  end

  // record capture, only the first five bytes are stored
  always_ff @(posedge clk) begin
    if (step && rec_we) begin
      record_bytes[record_index[RIDX_BITS-1:0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mtp_out_fifo.sv
// two-word result buffer between the parser and the result channel
// depends on mtp_pkg
`default_nettype none

module mtp_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mtp_pkg::result_t  push_data,
  output logic [$clog2(mtp_pkg::RESULT_DEPTH+1)-1:0] level,
  input  wire logic              pop_ready,
  output logic                   out_valid,
  output mtp_pkg::result_t       out_data
);
  import mtp_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(RESULT_DEPTH);
  localparam int unsigned LVL_BITS = $clog2(RESULT_DEPTH + 1);

  result_t               mem [RESULT_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic                  pop;

  assign out_valid = (level != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(RESULT_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(RESULT_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        level <= level + LVL_BITS'(1);
      end else if (pop && !push) begin
        level <= level - LVL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/minutia_template_parser.sv
// top level of the minutiae template parser: input register, parser, result buffer
// depends on mtp_pkg, mtp_parse, mtp_out_fifo
`default_nettype none

// Takes a minutiae template one byte per word and returns a header word after
// header byte 27, then one word per 6-byte minutia record, the final one marked
// last. Throughput is one byte per cycle while the result buffer has room: a taken
// byte is parsed while it sits in the input register, and its result is written
// into a two-word buffer, which drives result_valid; a result word thus passes the
// input register and then the buffer. The input side stalls only while the result
// buffer is full. A set first_byte restarts parsing with that byte as header
// byte 0; bytes after the last record are dropped.
module minutia_template_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             kind,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [7:0]       minutia_count,
  output logic [13:0]      pos_x,
  output logic [13:0]      pos_y,
  output logic [7:0]       angle_code,
  output logic [1:0]       minutia_type,
  output logic [7:0]       minutia_quality,
  output logic             last
);
  import mtp_pkg::*;

  localparam int unsigned LVL_BITS = $clog2(RESULT_DEPTH + 1);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_first;
  logic                step;
  logic                room;
  logic                res_valid;
  result_t             res;
  result_t             out_word;
  logic [LVL_BITS-1:0] level;

  // the buffer has room for the word this byte may make
  assign room       = (level != LVL_BITS'(RESULT_DEPTH));
  assign step       = s1_valid && room;
  assign data_ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_ready) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
    end
  end

  mtp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (s1_byte),
    .first_byte (s1_first),
    .res_valid  (res_valid),
    .res        (res)
  );

  mtp_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .level     (level),
    .pop_ready (result_ready),
    .out_valid (result_valid),
    .out_data  (out_word)
  );

  assign kind            = out_word.kind;
  assign image_width     = out_word.image_width;
  assign image_height    = out_word.image_height;
  assign minutia_count   = out_word.minutia_count;
  assign pos_x           = out_word.pos_x;
  assign pos_y           = out_word.pos_y;
  assign angle_code      = out_word.angle_code;
  assign minutia_type    = out_word.minutia_type;
  assign minutia_quality = out_word.minutia_quality;
  assign last            = out_word.last;

  // never write a result word into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (level != LVL_BITS'(RESULT_DEPTH)))
    else $error("result buffer overflow");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_BITS'(RESULT_DEPTH))
    else $error("result buffer level out of range");

  // a header with no minutiae closes the template
  a_empty_header_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_HEADER && res.minutia_count == 8'd0) |-> res.last)
    else $error("empty template header not marked last");

  // a stalled input register keeps its byte
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !room) |=> (s1_valid && $stable(s1_byte) && $stable(s1_first)))
    else $error("input register changed while stalled");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking bench for minutia_template_parser: directed templates, then random byte streams
// depends on mtp_pkg and the minutia_template_parser rtl
`timescale 1ns / 100ps

module tb_top;
  import mtp_pkg::*;

  localparam int RANDOM_BYTES = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 10;

  logic        clk;
  logic        rst;
  logic        data_valid;
  logic        data_ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        result_valid;
  logic        result_ready;
  logic        kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  minutia_count;
  logic [13:0] pos_x;
  logic [13:0] pos_y;
  logic [7:0]  angle_code;
  logic [1:0]  minutia_type;
  logic [7:0]  minutia_quality;
  logic        last;

  minutia_template_parser dut (.*);

  // one directed template: header shape, records sent, bytes after them
  typedef struct packed {
    logic        use_first;
    logic [4:0]  hdr_bytes;
    logic [7:0]  fill;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  count;
    logic [7:0]  recs;
    logic [3:0]  tail;
    logic [15:0] xw;
    logic [15:0] yw;
    logic [7:0]  ang;
    logic [7:0]  qual;
    logic        typed;
    logic [15:0] exp_width;
    logic [15:0] exp_height;
    logic [7:0]  exp_count;
    logic        exp_last;
  } tmpl_row_t;

  tmpl_row_t plan [9] = '{
    // no first_byte after reset, zero count, trailing bytes dropped
    '{1'b0, 5'd28, 8'h00, 16'h0000, 16'h0000, 8'd0, 8'd0, 4'd3, 16'h0000, 16'h0000,
      8'h00, 8'h00, 1'b1, 16'h0000, 16'h0000, 8'd0, 1'b1},
    '{1'b1, 5'd28, 8'hff, 16'hffff, 16'hffff, 8'd1, 8'd1, 4'd0, 16'hffff, 16'hffff,
      8'h00, 8'hff, 1'b1, 16'hffff, 16'hffff, 8'd1, 1'b0},
    '{1'b1, 5'd28, 8'h5a, 16'h1234, 16'h8001, 8'd2, 8'd2, 4'd4, 16'h4000, 16'hc000,
      8'h01, 8'h00, 1'b1, 16'h1234, 16'h8001, 8'd2, 1'b0},
    // header cut short by the next restart
    '{1'b1, 5'd16, 8'ha5, 16'hbeef, 16'hcafe, 8'd9, 8'd0, 4'd0, 16'h0000, 16'h0000,
      8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0},
    // record cut short by the next restart
    '{1'b1, 5'd28, 8'h3c, 16'h0100, 16'h0001, 8'd3, 8'd1, 4'd3, 16'h8000, 16'h3fff,
      8'h80, 8'h7f, 1'b1, 16'h0100, 16'h0001, 8'd3, 1'b0},
    '{1'b1, 5'd28, 8'hc3, 16'h00ff, 16'hff00, 8'd255, 8'd0, 4'd0, 16'h0000, 16'h0000,
      8'h00, 8'h00, 1'b1, 16'h00ff, 16'hff00, 8'd255, 1'b0},
    '{1'b1, 5'd28, 8'h00, 16'h0280, 16'h01e0, 8'd20, 8'd20, 4'd2, 16'h0001, 16'h0002,
      8'h02, 8'h10, 1'b1, 16'h0280, 16'h01e0, 8'd20, 1'b0},
    // no first_byte after trailing bytes: the whole template is dropped
    '{1'b0, 5'd28, 8'h11, 16'h1111, 16'h2222, 8'd1, 8'd1, 4'd0, 16'h1111, 16'h2222,
      8'h33, 8'h44, 1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0},
    '{1'b1, 5'd28, 8'hee, 16'h7fff, 16'h8000, 8'd1, 8'd1, 4'd0, 16'h7fff, 16'h8000,
      8'hff, 8'h80, 1'b1, 16'h7fff, 16'h8000, 8'd1, 1'b0}
  };

  // parser state mirrored by the predictor
  logic [4:0]  hdr_pos = '0;
  logic [2:0]  rec_pos = '0;
  logic [15:0] cap_width = '0;
  logic [15:0] cap_height = '0;
  logic [7:0]  cap_count = '0;
  logic [7:0]  recs_left = '0;
  logic [7:0]  rec_buf [5];
  logic        in_body = 1'b0;

  result_t pending_results [$];
  result_t want_word;
  result_t typed_hdr;
  bit      typed_hdr_armed = 1'b0;
  bit      idle_en = 1'b1;
  bit      hold_long = 1'b0;
  int      mismatches = 0;
  int      bytes_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic parse_byte(input logic [7:0] b, input logic f, output bit got,
                            output result_t r);
    logic [15:0] xw;
    logic [15:0] yw;
    got = 1'b0;
    r = '0;
    if (f) begin
      hdr_pos = '0;
      rec_pos = '0;
      recs_left = '0;
      in_body = 1'b0;
    end
    if (!in_body) begin
      case (hdr_pos)
        WIDTH_HI_BYTE:    cap_width[15:8] = b;
        WIDTH_LO_BYTE:    cap_width[7:0] = b;
        HEIGHT_HI_BYTE:   cap_height[15:8] = b;
        HEIGHT_LO_BYTE:   cap_height[7:0] = b;
        HEADER_LAST_BYTE: cap_count = b;
        default: ;
      endcase
      if (hdr_pos >= HEADER_LAST_BYTE) begin
        in_body = 1'b1;
        recs_left = cap_count;
        rec_pos = '0;
        got = 1'b1;
        r.kind = KIND_HEADER;
        r.image_width = cap_width;
        r.image_height = cap_height;
        r.minutia_count = cap_count;
        r.last = (cap_count == 8'd0);
      end else begin
        hdr_pos = hdr_pos + 5'd1;
      end
    end else if (recs_left != 8'd0) begin
      if (rec_pos < RECORD_LEN - 1) begin
        rec_buf[rec_pos] = b;
        rec_pos = rec_pos + 3'd1;
      end else begin
        xw = {rec_buf[0], rec_buf[1]};
        yw = {rec_buf[2], rec_buf[3]};
        recs_left = recs_left - 8'd1;
        rec_pos = '0;
        got = 1'b1;
        r.kind = KIND_MINUTIA;
        r.image_width = cap_width;
        r.image_height = cap_height;
        r.minutia_count = cap_count;
        r.pos_x = xw[13:0];
        r.pos_y = yw[13:0];
        r.angle_code = 8'd0 - rec_buf[4];
        r.minutia_type = xw[15:14];
        r.minutia_quality = b;
        r.last = (recs_left == 8'd0);
      end
    end
  endtask

  // offer one byte, predict once it is taken; returns at the following falling edge
  task automatic send_byte(input logic [7:0] b, input logic f);
    bit      got;
    result_t r;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    do @(posedge clk); while (!data_ready);
    parse_byte(b, f, got, r);
    if (got) begin
      if (typed_hdr_armed && r.kind == KIND_HEADER) begin
        pending_results.push_back(typed_hdr);
        typed_hdr_armed = 1'b0;
      end else begin
        pending_results.push_back(r);
      end
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_template(input logic use_first, input int hdr_bytes,
                               input logic [7:0] fill, input logic [15:0] w, h,
                               input logic [7:0] cnt, input int recs, input int tail,
                               input logic [15:0] xw, yw, input logic [7:0] ang, qual);
    int          k;
    int          i;
    logic [7:0]  b;
    logic [15:0] xi;
    logic [15:0] yi;
    for (k = 0; k < hdr_bytes; k++) begin
      case (k)
        WIDTH_HI_BYTE:    b = w[15:8];
        WIDTH_LO_BYTE:    b = w[7:0];
        HEIGHT_HI_BYTE:   b = h[15:8];
        HEIGHT_LO_BYTE:   b = h[7:0];
        HEADER_LAST_BYTE: b = cnt;
        default:          b = fill ^ 8'(k);
      endcase
      send_byte(b, (k == 0) ? use_first : 1'b0);
    end
    for (i = 0; i < recs; i++) begin
      xi = xw + 16'(i);
      yi = yw - 16'(i);
      send_byte(xi[15:8], 1'b0);
      send_byte(xi[7:0], 1'b0);
      send_byte(yi[15:8], 1'b0);
      send_byte(yi[7:0], 1'b0);
      send_byte(ang + 8'(i), 1'b0);
      send_byte(qual ^ 8'(i), 1'b0);
    end
    repeat (tail) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, kind %0b last %0b", $time, kind, last);
        mismatches++;
      end else begin
        want_word = pending_results.pop_front();
        check_field("kind", want_word.kind, kind);
        check_field("image_width", want_word.image_width, image_width);
        check_field("image_height", want_word.image_height, image_height);
        check_field("minutia_count", want_word.minutia_count, minutia_count);
        check_field("pos_x", want_word.pos_x, pos_x);
        check_field("pos_y", want_word.pos_y, pos_y);
        check_field("angle_code", want_word.angle_code, angle_code);
        check_field("minutia_type", want_word.minutia_type, minutia_type);
        check_field("minutia_quality", want_word.minutia_quality, minutia_quality);
        check_field("last", want_word.last, last);
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    result_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        result_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_long = 1'b0;
        result_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    int          r;
    int          rand_start;
    int          done;
    int          shape;
    int          hdr_n;
    int          recs;
    int          tail;
    logic [7:0]  cnt;
    bit          paused;
    rst = 1'b1;
    data_valid = 1'b0;
    data_byte = '0;
    first_byte = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < 9; r++) begin
      typed_hdr = '0;
      typed_hdr.kind = KIND_HEADER;
      typed_hdr.image_width = plan[r].exp_width;
      typed_hdr.image_height = plan[r].exp_height;
      typed_hdr.minutia_count = plan[r].exp_count;
      typed_hdr.last = plan[r].exp_last;
      typed_hdr_armed = plan[r].typed;
      send_template(plan[r].use_first, int'(plan[r].hdr_bytes), plan[r].fill,
                    plan[r].width, plan[r].height, plan[r].count, int'(plan[r].recs),
                    int'(plan[r].tail), plan[r].xw, plan[r].yw, plan[r].ang, plan[r].qual);
      typed_hdr_armed = 1'b0;
    end

    // random streams: mostly well-formed templates, some noise and broken ones
    rand_start = bytes_sent;
    hold_long = 1'b1;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      done = bytes_sent - rand_start;
      idle_en = (done < RANDOM_BYTES - 100) && ($urandom_range(0, 3) != 0);
      if (!paused && done > RANDOM_BYTES / 2) begin
        paused = 1'b1;
        data_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        cnt = (shape == 1) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(0, 6));
        hdr_n = (shape == 2) ? $urandom_range(1, 27) : 28;
        recs = (shape == 3) ? $urandom_range(0, cnt) : int'(cnt);
        tail = (shape == 3 || shape == 4) ? $urandom_range(1, 5) : $urandom_range(0, 1);
        send_template(shape != 5, hdr_n, 8'($urandom), 16'($urandom), 16'($urandom), cnt,
                      recs, tail, 16'($urandom), 16'($urandom), 8'($urandom),
                      8'($urandom));
      end
    end
    data_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
